### rtl/running_leader_tracker_time_query_top_defines.svh
// assertion macros shared by the leader tracker rtl
// needs a clock named clk and a reset named rst in the including module
`ifndef RUNNING_LEADER_TRACKER_TIME_QUERY_TOP_DEFINES_SVH
`define RUNNING_LEADER_TRACKER_TIME_QUERY_TOP_DEFINES_SVH

// checked at every clock edge outside reset
`define RLTQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every clock edge, reset included
`define RLTQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/rltq_pkg.sv
// shared types and constants for the running leader tracker
// no dependencies
package rltq_pkg;

  localparam int PERSON_W = 8;
  localparam int STAMP_W  = 32;
  localparam int STATUS_W = 2;

  localparam int DEF_MAX_CANDIDATES = 256;
  localparam int DEF_MAX_VOTES      = 1024;

  localparam logic ACT_VOTE  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

endpackage

### rtl/rltq_ram.sv
// generic single write port ram with one registered read port
// no dependencies
module rltq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/running_leader_tracker_time_query_top.sv
// running leader tracker with time queries: vote counting, history and search sequencer
// depends on rltq_pkg, rltq_ram and the assertion macro header
//
// Usage: a request is taken when start is high and busy is low. action selects a vote
// (person, stamp) or a query (stamp). Every request gives exactly one result on leader and
// status, shown for a single cycle with done high; the receiver cannot hold it off.
// A vote reads the candidate's count from the count ram, adds one and writes back together
// with one history entry, through the states S_VREAD and S_VCALC. A vote with the
// history full, or for a candidate at or beyond MAX_CANDIDATES, answers in the next cycle.
// A query runs a binary search over the history ram with one shared compare unit: each
// probe is a registered ram read, then compare and narrow. busy stays high from the
// request until done is shown (a refused vote never raises it), so one request is in
// flight at a time. After reset the count ram is swept to zero, one entry per cycle,
// with busy high until the sweep ends. Counts, top count, current leader and history
// length are then zero.
`include "running_leader_tracker_time_query_top_defines.svh"

module running_leader_tracker_time_query_top #(
  parameter int MAX_CANDIDATES = rltq_pkg::DEF_MAX_CANDIDATES,
  parameter int MAX_VOTES      = rltq_pkg::DEF_MAX_VOTES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          action,
  input  logic [rltq_pkg::PERSON_W-1:0] person,
  input  logic [rltq_pkg::STAMP_W-1:0]  stamp,
  output logic                          done,
  output logic [rltq_pkg::PERSON_W-1:0] leader,
  output logic [rltq_pkg::STATUS_W-1:0] status
);

  import rltq_pkg::*;

  localparam int CA = $clog2(MAX_CANDIDATES);
  localparam int HA = $clog2(MAX_VOTES);
  localparam int EW = $clog2(MAX_VOTES + 1);
  localparam int HW = PERSON_W + STAMP_W;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_VREAD  = 7'b0000100,
    S_VCALC  = 7'b0001000,
    S_QPROBE = 7'b0010000,
    S_QCMP   = 7'b0100000,
    S_QOUT   = 7'b1000000
  } state_t;

  state_t               state;
  logic [CA-1:0]        clr;
  logic [EW-1:0]        entries;
  logic [EW-1:0]        top_count;
  logic [PERSON_W-1:0]  cur_leader;
  logic [PERSON_W-1:0]  person_q;
  logic [STAMP_W-1:0]   stamp_q;
  logic [EW-1:0]        lo;
  logic [EW-1:0]        hi;
  logic [EW-1:0]        mid;

  logic                 accept;
  logic                 hist_full;
  logic                 person_bad;
  logic [CA-1:0]        cnt_addr;
  logic                 cnt_we;
  logic [CA-1:0]        cnt_waddr;
  logic [EW-1:0]        cnt_wdata;
  logic [EW-1:0]        cnt_rdata;
  logic [EW-1:0]        cnt_new;
  logic                 take_lead;
  logic [PERSON_W-1:0]  leader_new;
  logic                 hist_we;
  logic [HW-1:0]        hist_wdata;
  logic [HA-1:0]        hist_raddr;
  logic [HW-1:0]        hist_rdata;
  logic                 search_open;
  logic [EW-1:0]        mid_calc;
  logic [EW-1:0]        lo_m1;
  logic                 stamp_le;

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign hist_full  = (entries >= EW'(MAX_VOTES));
  assign person_bad = (int'(person) >= MAX_CANDIDATES);

  // count ram: swept to zero after reset, read-modify-write on a vote
  assign cnt_addr   = CA'(person_q);
  assign cnt_new    = cnt_rdata + EW'(1);
  assign take_lead  = (cnt_new >= top_count);
  assign leader_new = take_lead ? person_q : cur_leader;
  assign cnt_we     = (state == S_CLEAR) || (state == S_VCALC);
  assign cnt_waddr  = (state == S_CLEAR) ? clr : cnt_addr;
  assign cnt_wdata  = (state == S_CLEAR) ? '0 : cnt_new;

  rltq_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_CANDIDATES)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_addr),
    .rdata (cnt_rdata)
  );

  // shared search unit: midpoint, last-entry index and stamp compare
  assign search_open = (lo < hi);
  assign mid_calc    = lo + ((hi - lo) >> 1);
  assign lo_m1       = lo - EW'(1);
  assign stamp_le    = (hist_rdata[STAMP_W-1:0] <= stamp_q);
  assign hist_raddr  = search_open ? mid_calc[HA-1:0] : lo_m1[HA-1:0];

  assign hist_we    = (state == S_VCALC);
  assign hist_wdata = {leader_new, stamp_q};

  rltq_ram #(
    .WIDTH (HW),
    .DEPTH (MAX_VOTES)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (entries[HA-1:0]),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr        <= '0;
      entries    <= '0;
      top_count  <= '0;
      cur_leader <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + CA'(1);
          if (clr == CA'(MAX_CANDIDATES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (action == ACT_QUERY) begin
              state <= S_QPROBE;
            end else if (hist_full || person_bad) begin
              done <= 1'b1;
            end else begin
              state <= S_VREAD;
            end
          end
        end
        S_VREAD: begin
          state <= S_VCALC;
        end
        S_VCALC: begin
          if (take_lead) begin
            top_count  <= cnt_new;
            cur_leader <= person_q;
          end
          entries <= entries + EW'(1);
          done    <= 1'b1;
          state   <= S_IDLE;
        end
        S_QPROBE: begin
          if (search_open) begin
            state <= S_QCMP;
          end else if (lo == '0) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_QOUT;
          end
        end
        S_QCMP: begin
          state <= S_QPROBE;
        end
        S_QOUT: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request payload, search bounds and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      person_q <= person;
      stamp_q  <= stamp;
      lo       <= '0;
      hi       <= entries;
      leader   <= cur_leader;
      status   <= hist_full && (action == ACT_VOTE) ? ST_FULL : ST_OK;
    end
    if (state == S_QPROBE && search_open) begin
      mid <= mid_calc;
    end
    if (state == S_QCMP) begin
      if (stamp_le) begin
        lo <= mid + EW'(1);
      end else begin
        hi <= mid;
      end
    end
    if (state == S_VCALC) begin
      leader <= leader_new;
      status <= ST_OK;
    end
    if (state == S_QPROBE && !search_open && lo == '0) begin
      leader <= '0;
      status <= ST_NONE;
    end
    if (state == S_QOUT) begin
      leader <= hist_rdata[HW-1:STAMP_W];
      status <= ST_OK;
    end
  end

  `RLTQ_ASSERT(a_done_not_busy, done |-> !busy, "result shown while a request is still busy")
  `RLTQ_ASSERT(a_search_bounds, (state == S_QPROBE) |-> (lo <= hi), "search bounds crossed")
  `RLTQ_ASSERT(a_entries_cap, entries <= EW'(MAX_VOTES), "history length beyond capacity")
  `RLTQ_ASSERT(a_full_only_full, (done && status == ST_FULL) |-> hist_full, "full flagged with room left")
  `RLTQ_ASSERT(a_top_follows, (state == S_VCALC && take_lead) |=> (top_count == $past(cnt_new)), "top count not updated on a lead change")
  `RLTQ_ASSERT_ALWAYS(a_reset_clear, rst |=> (state == S_CLEAR && !done), "reset does not start the clearing sweep")

endmodule

### test/running_leader_tracker_time_query_top_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the running leader tracker with time queries
// depends on rltq_pkg and running_leader_tracker_time_query_top; keeps its own tally and history
module running_leader_tracker_time_query_top_test;
  import rltq_pkg::*;

  localparam int CANDIDATES    = DEF_MAX_CANDIDATES;
  localparam int HISTORY_DEPTH = DEF_MAX_VOTES;
  localparam int RANDOM_ITEMS  = 2000;
  localparam int AFTER_FULL    = 300;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int TAIL_CYCLES   = 40;

  typedef struct packed {
    logic [PERSON_W-1:0] leader;
    logic [STATUS_W-1:0] status;
  } answer_t;

  typedef struct packed {
    logic                act;
    logic [PERSON_W-1:0] who;
    logic [STAMP_W-1:0]  t;
    logic                typed;
    logic [PERSON_W-1:0] leader;
    logic [STATUS_W-1:0] status;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 22;
  // typed rows carry their answer, the rest are checked against the tally
  localparam stim_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
    '{ACT_QUERY, 8'd0,   32'h0000_0000, 1'b1, 8'd0,   ST_NONE},
    '{ACT_QUERY, 8'd255, 32'hFFFF_FFFF, 1'b1, 8'd0,   ST_NONE},
    '{ACT_VOTE,  8'd0,   32'd100,       1'b1, 8'd0,   ST_OK},
    '{ACT_QUERY, 8'd0,   32'd99,        1'b1, 8'd0,   ST_NONE},
    '{ACT_QUERY, 8'd0,   32'd100,       1'b1, 8'd0,   ST_OK},
    '{ACT_VOTE,  8'd255, 32'd100,       1'b1, 8'd255, ST_OK},
    '{ACT_QUERY, 8'd0,   32'd100,       1'b0, 8'd0,   ST_OK},
    '{ACT_VOTE,  8'd255, 32'd200,       1'b0, 8'd0,   ST_OK},
    '{ACT_VOTE,  8'd0,   32'd200,       1'b0, 8'd0,   ST_OK},
    '{ACT_VOTE,  8'd170, 32'd300,       1'b0, 8'd0,   ST_OK},
    '{ACT_QUERY, 8'd85,  32'd150,       1'b0, 8'd0,   ST_OK},
    '{ACT_QUERY, 8'd0,   32'd199,       1'b0, 8'd0,   ST_OK},
    '{ACT_QUERY, 8'd0,   32'd200,       1'b0, 8'd0,   ST_OK},
    '{ACT_QUERY, 8'd0,   32'hFFFF_FFFF, 1'b0, 8'd0,   ST_OK},
    '{ACT_VOTE,  8'd85,  32'hFFFF_FFFF, 1'b0, 8'd0,   ST_OK},
    '{ACT_VOTE,  8'd85,  32'h0000_0000, 1'b0, 8'd0,   ST_OK},
    '{ACT_VOTE,  8'd1,   32'd50,        1'b0, 8'd0,   ST_OK},
    '{ACT_QUERY, 8'd0,   32'h0000_0000, 1'b0, 8'd0,   ST_OK},
    '{ACT_QUERY, 8'd0,   32'd60,        1'b0, 8'd0,   ST_OK},
    '{ACT_QUERY, 8'd0,   32'h8000_0000, 1'b0, 8'd0,   ST_OK},
    '{ACT_QUERY, 8'd0,   32'hFFFF_FFFE, 1'b0, 8'd0,   ST_OK},
    '{ACT_QUERY, 8'd0,   32'hFFFF_FFFF, 1'b0, 8'd0,   ST_OK}
  };

  logic                clk;
  logic                rst    = 1'b1;
  logic                start  = 1'b0;
  logic                action = ACT_VOTE;
  logic [PERSON_W-1:0] person = '0;
  logic [STAMP_W-1:0]  stamp  = '0;
  logic                busy;
  logic                done;
  logic [PERSON_W-1:0] leader;
  logic [STATUS_W-1:0] status;

  running_leader_tracker_time_query_top #(
    .MAX_CANDIDATES(CANDIDATES),
    .MAX_VOTES     (HISTORY_DEPTH)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .action(action),
    .person(person),
    .stamp (stamp),
    .done  (done),
    .leader(leader),
    .status(status)
  );

  // tracker state as the block should hold it
  logic [10:0]         tally [0:CANDIDATES-1];
  logic [10:0]         top_tally;
  logic [PERSON_W-1:0] leader_now;
  logic [PERSON_W-1:0] hist_leader [0:HISTORY_DEPTH-1];
  logic [STAMP_W-1:0]  hist_stamp [0:HISTORY_DEPTH-1];
  logic [10:0]         hist_len;

  answer_t expected_answers[$];
  int      mismatches = 0;
  int      cycles = 0;
  bit      no_idle = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic answer_t predict_answer(input logic act, input logic [PERSON_W-1:0] who,
                                             input logic [STAMP_W-1:0] t);
    answer_t a;
    int      lo;
    int      hi;
    int      mid;
    if (act == ACT_VOTE) begin
      if (hist_len >= HISTORY_DEPTH) begin
        a.leader = leader_now;
        a.status = ST_FULL;
        return a;
      end
      if (int'(who) >= CANDIDATES) begin
        a.leader = leader_now;
        a.status = ST_OK;
        return a;
      end
      tally[who] = tally[who] + 11'd1;
      // ties go to the latest vote
      if (tally[who] >= top_tally) begin
        top_tally  = tally[who];
        leader_now = who;
      end
      hist_leader[hist_len] = leader_now;
      hist_stamp[hist_len]  = t;
      hist_len = hist_len + 11'd1;
      a.leader = leader_now;
      a.status = ST_OK;
      return a;
    end
    // first entry stamped after t, answer is the one just before it
    lo = 0;
    hi = int'(hist_len);
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (hist_stamp[mid] <= t) lo = mid + 1;
      else hi = mid;
    end
    if (lo == 0) begin
      a.leader = '0;
      a.status = ST_NONE;
    end else begin
      a.leader = hist_leader[lo-1];
      a.status = ST_OK;
    end
    return a;
  endfunction

  // drives one request and returns at the edge that takes it
  task automatic send_request(input logic act, input logic [PERSON_W-1:0] who,
                              input logic [STAMP_W-1:0] t, input logic typed,
                              input answer_t typed_answer);
    answer_t predicted;
    start  <= 1'b1;
    action <= act;
    person <= who;
    stamp  <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = predict_answer(act, who, t);
    expected_answers.insert(expected_answers.size(), typed ? typed_answer : predicted);
  endtask

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic idle_sender();
    int n;
    n = pick_gap();
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_answers();
    start <= 1'b0;
    @(posedge clk);
    while (expected_answers.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (!rst && done) begin
      if (expected_answers.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result leader %0d status %0d", $time, leader, status);
      end else begin
        want = expected_answers.pop_front();
        if (leader !== want.leader) begin
          mismatches++;
          $display("%0t: leader expected %0d actual %0d", $time, want.leader, leader);
        end
        if (status !== want.status) begin
          mismatches++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("running_leader_tracker_time_query_top verification failed");
      $finish;
    end
  end

  initial begin
    answer_t             typed_answer;
    logic [STAMP_W-1:0]  now_stamp;
    logic [32:0]         sum;
    logic                act;
    logic [PERSON_W-1:0] who;
    logic [STAMP_W-1:0]  t;
    int                  sent;
    int                  since_full;
    int                  r;
    int                  idx;

    for (int i = 0; i < CANDIDATES; i++) tally[i] = '0;
    top_tally  = '0;
    leader_now = '0;
    hist_len   = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      typed_answer.leader = DIRECTED[i].leader;
      typed_answer.status = DIRECTED[i].status;
      send_request(DIRECTED[i].act, DIRECTED[i].who, DIRECTED[i].t, DIRECTED[i].typed,
                   typed_answer);
      idle_sender();
    end
    drain_answers();

    now_stamp  = 32'd400;
    sent       = 0;
    since_full = 0;
    typed_answer = '0;
    while (sent < RANDOM_ITEMS || hist_len < HISTORY_DEPTH || since_full < AFTER_FULL) begin
      if (sent % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (hist_len < HISTORY_DEPTH) act = ($urandom_range(0, 99) < 60) ? ACT_VOTE : ACT_QUERY;
      else act = ($urandom_range(0, 99) < 35) ? ACT_VOTE : ACT_QUERY;

      who = ($urandom_range(0, 99) < 70) ? PERSON_W'($urandom_range(0, 5))
                                          : PERSON_W'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (act == ACT_VOTE) begin
        if (r < 5) begin
          // out of order stamp
          t = $urandom;
        end else begin
          if (r < 40) sum = {1'b0, now_stamp};
          else if (r < 90) sum = {1'b0, now_stamp} + 33'($urandom_range(1, 5));
          else sum = {1'b0, now_stamp} + 33'($urandom_range(0, 32'h000F_FFFF));
          now_stamp = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          t = now_stamp;
        end
      end else begin
        if (r < 45) begin
          t = $urandom_range(0, now_stamp);
        end else if (r < 60) begin
          t = now_stamp + 32'($urandom_range(0, 2));
        end else if (r < 75) begin
          t = $urandom;
        end else if (hist_len != 0) begin
          // close to a recorded stamp, equal stamps come out here
          idx = $urandom_range(0, int'(hist_len) - 1);
          t   = hist_stamp[idx] + 32'($urandom_range(0, 2)) - 32'd1;
        end else begin
          t = '0;
        end
      end

      send_request(act, who, t, 1'b0, typed_answer);
      sent++;
      if (hist_len >= HISTORY_DEPTH) since_full++;
      if (sent % 250 == 0) drain_answers();
      else idle_sender();
    end

    start <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("running_leader_tracker_time_query_top verification clean");
    end else begin
      $display("running_leader_tracker_time_query_top verification failed");
    end
    $finish;
  end

endmodule
